[rtl/ntct_pkg.sv]
// ============================================================================
// ntct_pkg
// Shared types, constants and the NTC resistance table for the thermistor
// to temperature converter.
// ============================================================================
package ntct_pkg;

    localparam int ADC_BITS_DEF      = 12;
    localparam int CHANNELS_DEF      = 4;
    localparam int TABLE_ENTRIES_DEF = 166;

    localparam int TBL_FULL = 166;
    localparam int TBL_W    = 22;
    localparam int TIDX_W   = 8;
    localparam int DEN2_W   = 20;
    localparam int RES_W    = 23;
    localparam int TEMP_W   = 16;
    localparam int SC_W     = 24;
    localparam int CODE_W   = 12;
    localparam int CH_W     = 2;
    localparam int CFG_W    = 20;
    localparam int THR_W    = 12;
    localparam int FRAC_W   = 9;

    localparam logic [RES_W-1:0]  RES_MAX    = 23'd8388607;
    localparam int                T_FIRST_Q8 = -10240;
    localparam logic [CFG_W-1:0]  SERIES_RST = 20'd10000;
    localparam logic [THR_W-1:0]  THR_RST    = 12'd124;

    typedef enum logic [0:0] {
        CFG_SERIES = 1'b0,
        CFG_THRESH = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [CODE_W-1:0] adc_code;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]          channel_out;
        logic                     present;
        logic signed [TEMP_W-1:0] temperature;
        logic [RES_W-1:0]         resistance_tenths;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_start;
        logic res_capture;
        logic range;
        logic srch_step;
        logic fetch;
        logic temp_capture;
        logic write;
    } ntct_cmd_t;

    typedef struct packed {
        logic present;
        logic cold;
        logic hot;
        logic srch_last;
        logic div_done;
    } ntct_sts_t;

    function automatic logic [TBL_W-1:0] ntc_tenths(input logic [TIDX_W-1:0] idx);
        logic [TBL_W-1:0] v;
        case (idx)
            8'd0: v = 22'd3436326;   8'd1: v = 22'd3212809;   8'd2: v = 22'd3005339;
            8'd3: v = 22'd2812660;   8'd4: v = 22'd2633624;   8'd5: v = 22'd2467177;
            8'd6: v = 22'd2312355;   8'd7: v = 22'd2168273;   8'd8: v = 22'd2034118;
            8'd9: v = 22'd1909144;   8'd10: v = 22'd1792666;  8'd11: v = 22'd1684053;
            8'd12: v = 22'd1582726;  8'd13: v = 22'd1488151;  8'd14: v = 22'd1399837;
            8'd15: v = 22'd1317332;  8'd16: v = 22'd1240216;  8'd17: v = 22'd1168107;
            8'd18: v = 22'd1100648;  8'd19: v = 22'd1037512;  8'd20: v = 22'd978396;
            8'd21: v = 22'd923020;   8'd22: v = 22'd871124;   8'd23: v = 22'd822471;
            8'd24: v = 22'd776837;   8'd25: v = 22'd734018;   8'd26: v = 22'd693823;
            8'd27: v = 22'd656077;   8'd28: v = 22'd620616;   8'd29: v = 22'd587288;
            8'd30: v = 22'd555953;   8'd31: v = 22'd526480;   8'd32: v = 22'd498747;
            8'd33: v = 22'd472643;   8'd34: v = 22'd448062;   8'd35: v = 22'd424906;
            8'd36: v = 22'd403086;   8'd37: v = 22'd382516;   8'd38: v = 22'd363117;
            8'd39: v = 22'd344817;   8'd40: v = 22'd327547;   8'd41: v = 22'd311243;
            8'd42: v = 22'd295847;   8'd43: v = 22'd281301;   8'd44: v = 22'd267556;
            8'd45: v = 22'd254562;   8'd46: v = 22'd242274;   8'd47: v = 22'd230650;
            8'd48: v = 22'd219650;   8'd49: v = 22'd209239;   8'd50: v = 22'd199380;
            8'd51: v = 22'd190041;   8'd52: v = 22'd181193;   8'd53: v = 22'd172807;
            8'd54: v = 22'd164857;   8'd55: v = 22'd157317;   8'd56: v = 22'd150164;
            8'd57: v = 22'd143376;   8'd58: v = 22'd136933;   8'd59: v = 22'd130816;
            8'd60: v = 22'd125005;   8'd61: v = 22'd119485;   8'd62: v = 22'd114239;
            8'd63: v = 22'd109252;   8'd64: v = 22'd104510;   8'd65: v = 22'd100000;
            8'd66: v = 22'd95709;    8'd67: v = 22'd91626;    8'd68: v = 22'd87738;
            8'd69: v = 22'd84037;    8'd70: v = 22'd80512;    8'd71: v = 22'd77154;
            8'd72: v = 22'd73953;    8'd73: v = 22'd70903;    8'd74: v = 22'd67995;
            8'd75: v = 22'd65221;    8'd76: v = 22'd62576;    8'd77: v = 22'd60051;
            8'd78: v = 22'd57642;    8'd79: v = 22'd55342;    8'd80: v = 22'd53146;
            8'd81: v = 22'd51049;    8'd82: v = 22'd49045;    8'd83: v = 22'd47130;
            8'd84: v = 22'd45300;    8'd85: v = 22'd43551;    8'd86: v = 22'd41878;
            8'd87: v = 22'd40278;    8'd88: v = 22'd38748;    8'd89: v = 22'd37283;
            8'd90: v = 22'd35882;    8'd91: v = 22'd34540;    8'd92: v = 22'd33255;
            8'd93: v = 22'd32025;    8'd94: v = 22'd30846;    8'd95: v = 22'd29717;
            8'd96: v = 22'd28635;    8'd97: v = 22'd27597;    8'd98: v = 22'd26603;
            8'd99: v = 22'd25649;    8'd100: v = 22'd24734;   8'd101: v = 22'd23856;
            8'd102: v = 22'd23014;   8'd103: v = 22'd22206;   8'd104: v = 22'd21431;
            8'd105: v = 22'd20686;   8'd106: v = 22'd19970;   8'd107: v = 22'd19283;
            8'd108: v = 22'd18623;   8'd109: v = 22'd17989;   8'd110: v = 22'd17380;
            8'd111: v = 22'd16794;   8'd112: v = 22'd16231;   8'd113: v = 22'd15689;
            8'd114: v = 22'd15168;   8'd115: v = 22'd14667;   8'd116: v = 22'd14185;
            8'd117: v = 22'd13722;   8'd118: v = 22'd13275;   8'd119: v = 22'd12845;
            8'd120: v = 22'd12431;   8'd121: v = 22'd12033;   8'd122: v = 22'd11649;
            8'd123: v = 22'd11279;   8'd124: v = 22'd10923;   8'd125: v = 22'd10580;
            8'd126: v = 22'd10249;   8'd127: v = 22'd9930;    8'd128: v = 22'd9623;
            8'd129: v = 22'd9326;    8'd130: v = 22'd9040;    8'd131: v = 22'd8764;
            8'd132: v = 22'd8498;    8'd133: v = 22'd8241;    8'd134: v = 22'd7994;
            8'd135: v = 22'd7754;    8'd136: v = 22'd7523;    8'd137: v = 22'd7300;
            8'd138: v = 22'd7085;    8'd139: v = 22'd6877;    8'd140: v = 22'd6676;
            8'd141: v = 22'd6482;    8'd142: v = 22'd6295;    8'd143: v = 22'd6113;
            8'd144: v = 22'd5938;    8'd145: v = 22'd5769;    8'd146: v = 22'd5605;
            8'd147: v = 22'd5447;    8'd148: v = 22'd5293;    8'd149: v = 22'd5145;
            8'd150: v = 22'd5002;    8'd151: v = 22'd4863;    8'd152: v = 22'd4729;
            8'd153: v = 22'd4599;    8'd154: v = 22'd4474;    8'd155: v = 22'd4352;
            8'd156: v = 22'd4234;    8'd157: v = 22'd4120;    8'd158: v = 22'd4009;
            8'd159: v = 22'd3902;    8'd160: v = 22'd3799;    8'd161: v = 22'd3698;
            8'd162: v = 22'd3601;    8'd163: v = 22'd3506;    8'd164: v = 22'd3415;
            8'd165: v = 22'd3326;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/ntct_div.sv]
// ============================================================================
// ntct_div
// Restoring divider, one quotient bit per cycle, DVD_W quotient bits per division.
// ============================================================================
module ntct_div #(
    parameter int DVD_W = 41,
    parameter int DVS_W = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_diff;
    logic             fits;

    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign fits     = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(DVD_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

[rtl/ntct_dp.sv]
// ============================================================================
// ntct_dp
// Datapath: configuration registers, resistance product, shared divider,
// table search, interpolation, channel store and result register.
// ============================================================================
module ntct_dp #(
    parameter int ADC_BITS      = ntct_pkg::ADC_BITS_DEF,
    parameter int CHANNELS      = ntct_pkg::CHANNELS_DEF,
    parameter int TABLE_ENTRIES = ntct_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [0:0]                 cfg_index,
    input  logic [ntct_pkg::CFG_W-1:0] cfg_data,
    input  ntct_pkg::in_item_t         in_data,
    input  ntct_pkg::ntct_cmd_t        cmd,
    output ntct_pkg::ntct_sts_t        sts,
    output ntct_pkg::out_item_t        out_data
);

    localparam int TBL_USED = (TABLE_ENTRIES < ntct_pkg::TBL_FULL) ?
                              TABLE_ENTRIES : ntct_pkg::TBL_FULL;
    localparam int IDX_W    = $clog2(TBL_USED);
    localparam int SRCH_MAX = TBL_USED - 2;
    localparam int DIFF_W   = ADC_BITS + 1;
    localparam int NUM_W    = ntct_pkg::SC_W + DIFF_W;
    localparam int TW       = ntct_pkg::TEMP_W;
    localparam int RW       = ntct_pkg::RES_W;
    localparam logic [TW-1:0] TEMP_COLD = TW'(ntct_pkg::T_FIRST_Q8);
    localparam logic [TW-1:0] TEMP_HOT  = TW'(ntct_pkg::T_FIRST_Q8 + (TBL_USED - 1) * 256);

    logic [ntct_pkg::CFG_W-1:0]  series_reg;
    logic [ntct_pkg::THR_W-1:0]  thr_reg;
    logic [ntct_pkg::CH_W-1:0]   ch_reg;
    logic [ntct_pkg::CODE_W-1:0] code_reg;
    logic                        present_reg;
    logic [DIFF_W-1:0]           diff_reg;
    logic [ntct_pkg::SC_W-1:0]   sc10_reg;
    logic [NUM_W-1:0]            dvd_reg;
    logic [ntct_pkg::DEN2_W-1:0] dvs_reg;
    logic [RW-1:0]               res_reg;
    logic [TW-1:0]               temp_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [IDX_W-1:0]            bit_reg;
    logic [TW-1:0]               store_reg [CHANNELS];
    ntct_pkg::out_item_t         out_reg;

    logic [31:0]                 code32;
    logic [31:0]                 full32;
    logic [NUM_W-1:0]            prod;
    logic                        div_done;
    logic [NUM_W-1:0]            quot;
    logic [ntct_pkg::TBL_W-1:0]  tbl_first;
    logic [ntct_pkg::TBL_W-1:0]  tbl_last;
    logic [IDX_W-1:0]            cand;
    logic [ntct_pkg::TBL_W-1:0]  tbl_cand;
    logic                        take;
    logic [ntct_pkg::TBL_W-1:0]  tbl_hi;
    logic [ntct_pkg::TBL_W-1:0]  tbl_lo;
    logic [ntct_pkg::TBL_W-1:0]  num;
    logic [ntct_pkg::TBL_W-1:0]  den;
    logic [TW-1:0]               temp_base;

    assign code32 = 32'(in_data.adc_code);
    assign full32 = 32'(1) << ADC_BITS;
    assign prod   = sc10_reg * diff_reg;

    assign tbl_first = ntct_pkg::ntc_tenths(ntct_pkg::TIDX_W'(0));
    assign tbl_last  = ntct_pkg::ntc_tenths(ntct_pkg::TIDX_W'(TBL_USED - 1));
    assign cand      = idx_reg | bit_reg;
    assign tbl_cand  = ntct_pkg::ntc_tenths(ntct_pkg::TIDX_W'(cand));
    assign take      = (32'(cand) <= SRCH_MAX) && (RW'(tbl_cand) >= res_reg);
    assign tbl_hi    = ntct_pkg::ntc_tenths(ntct_pkg::TIDX_W'(idx_reg));
    assign tbl_lo    = ntct_pkg::ntc_tenths(ntct_pkg::TIDX_W'(idx_reg) +
                                            ntct_pkg::TIDX_W'(1));
    assign num       = tbl_hi - res_reg[ntct_pkg::TBL_W-1:0];
    assign den       = tbl_hi - tbl_lo;
    assign temp_base = TEMP_COLD + TW'({idx_reg, 8'h00});

    ntct_div #(
        .DVD_W (NUM_W),
        .DVS_W (ntct_pkg::DEN2_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_reg <= ntct_pkg::SERIES_RST;
            thr_reg    <= ntct_pkg::THR_RST;
            for (int k = 0; k < CHANNELS; k++)
            begin
                store_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    ntct_pkg::CFG_SERIES: series_reg <= cfg_data;
                    ntct_pkg::CFG_THRESH: thr_reg    <= cfg_data[ntct_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
            for (int k = 0; k < CHANNELS; k++)
            begin
                if (cmd.write && (32'(ch_reg) == k))
                begin
                    store_reg[k] <= temp_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg      <= in_data.channel;
            code_reg    <= in_data.adc_code;
            present_reg <= in_data.adc_code > thr_reg;
            diff_reg    <= (code32 < full32) ? DIFF_W'(full32 - code32) : '0;
            sc10_reg    <= ntct_pkg::SC_W'({series_reg, 3'b000}) +
                           ntct_pkg::SC_W'({series_reg, 1'b0});
            res_reg     <= '0;
            temp_reg    <= '0;
        end
        if (cmd.mul)
        begin
            dvd_reg <= prod;
            dvs_reg <= ntct_pkg::DEN2_W'(code_reg);
        end
        if (cmd.res_capture)
        begin
            res_reg <= (quot > NUM_W'(ntct_pkg::RES_MAX)) ? ntct_pkg::RES_MAX : quot[RW-1:0];
        end
        if (cmd.range)
        begin
            idx_reg <= '0;
            bit_reg <= IDX_W'(1) << (IDX_W - 1);
            if (sts.cold)
            begin
                temp_reg <= TEMP_COLD;
            end
            else if (sts.hot)
            begin
                temp_reg <= TEMP_HOT;
            end
        end
        if (cmd.srch_step)
        begin
            if (take)
            begin
                idx_reg <= cand;
            end
            bit_reg <= bit_reg >> 1;
        end
        if (cmd.fetch)
        begin
            dvd_reg <= NUM_W'({num, 9'b0_0000_0000}) + NUM_W'(den);
            dvs_reg <= ntct_pkg::DEN2_W'({den, 1'b0});
        end
        if (cmd.temp_capture)
        begin
            temp_reg <= temp_base + TW'(quot[ntct_pkg::FRAC_W-1:0]);
        end
        if (cmd.write)
        begin
            out_reg.channel_out       <= ch_reg;
            out_reg.present           <= present_reg;
            out_reg.temperature       <= $signed(temp_reg);
            out_reg.resistance_tenths <= res_reg;
        end
    end

    assign sts.present   = present_reg;
    assign sts.cold      = res_reg > RW'(tbl_first);
    assign sts.hot       = res_reg < RW'(tbl_last);
    assign sts.srch_last = bit_reg[0];
    assign sts.div_done  = div_done;
    assign out_data      = out_reg;

endmodule

[rtl/ntct_ctrl.sv]
// ============================================================================
// ntct_ctrl
// Controller: sequences load, divisions, table search and interpolation,
// and owns the input ready and output valid of the block.
// ============================================================================
module ntct_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ntct_pkg::ntct_sts_t sts,
    output ntct_pkg::ntct_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_D1,
        S_D1W,
        S_RANGE,
        S_SRCH,
        S_FETCH,
        S_D2,
        S_D2W,
        S_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.present)
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_D1;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_D1:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_D1W;
            end
            S_D1W:
            begin
                if (sts.div_done)
                begin
                    cmd.res_capture = 1'b1;
                    state_next      = S_RANGE;
                end
            end
            S_RANGE:
            begin
                cmd.range  = 1'b1;
                state_next = (sts.cold || sts.hot) ? S_WRITE : S_SRCH;
            end
            S_SRCH:
            begin
                cmd.srch_step = 1'b1;
                if (sts.srch_last)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_D2;
            end
            S_D2:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_D2W;
            end
            S_D2W:
            begin
                if (sts.div_done)
                begin
                    cmd.temp_capture = 1'b1;
                    state_next       = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (slot_free)
                begin
                    cmd.write      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (!out_valid_reg || out_ready))
        else $error("result written over a beat not yet taken");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_CHK))
        else $error("accepted beat did not start processing");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_D1W || state_reg == S_D2W))
        else $error("divider finished outside a wait state");

    a_valid_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_WRITE))
        else $error("result raised without a write");

endmodule

[rtl/ntc_thermistor_to_temperature.sv]
// ============================================================================
// ntc_thermistor_to_temperature
// NTC thermistor reading to temperature: divider resistance, table search
// and linear interpolation, one result beat per input beat.
// ============================================================================
// Input channel (in_valid/in_ready/in_data) takes a channel number and an
// ADC code; output channel (out_valid/out_ready/out_data) returns channel,
// presence flag, temperature in 1/256 C and resistance in 0.1 ohm.
// One beat is processed at a time. For an absent thermistor the sequencer
// goes from the presence check straight to the write; for a present one
// it runs the resistance division and the range check and, when the
// resistance lies inside the table, the table search steps and the
// interpolation division, both divisions using the shared one-bit-per-cycle
// divider. A new beat is taken only after the previous one is written.
// The result sits in an output register, so the next beat is accepted as
// soon as the previous one is written there; if the receiver stalls, a
// finished beat waits in the write state until the register frees up.
// Configuration writes (cfg_write_en, cfg_index, cfg_data) take effect at
// once. The user must make them only while the block is idle (not enforced).
// Reset clears the sequencer, the output valid and the channel store and
// loads the series resistor (10000 ohm) and presence threshold (124).
// ============================================================================
module ntc_thermistor_to_temperature #(
    parameter int ADC_BITS      = ntct_pkg::ADC_BITS_DEF,
    parameter int CHANNELS      = ntct_pkg::CHANNELS_DEF,
    parameter int TABLE_ENTRIES = ntct_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [0:0]                 cfg_index,
    input  logic [ntct_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ntct_pkg::in_item_t         in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ntct_pkg::out_item_t        out_data
);

    ntct_pkg::ntct_cmd_t cmd;
    ntct_pkg::ntct_sts_t sts;

    ntct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ntct_dp #(
        .ADC_BITS      (ADC_BITS),
        .CHANNELS      (CHANNELS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_data      (in_data),
        .cmd          (cmd),
        .sts          (sts),
        .out_data     (out_data)
    );

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the NTC thermistor to temperature converter.
// A driver pushes channel/ADC-code beats from a queue, a monitor compares each
// result beat against a predictor that recomputes the divider resistance and
// the interpolated table temperature, under several register settings with
// random gaps on both sides.
// ============================================================================
module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int FULL_SCALE     = 1 << ntct_pkg::ADC_BITS_DEF;
    localparam int HOTTEST_Q8     = ntct_pkg::T_FIRST_Q8 + (ntct_pkg::TBL_FULL - 1) * 256;

    localparam int unsigned THERM_CURVE [ntct_pkg::TBL_FULL] = '{
        3436326, 3212809, 3005339, 2812660, 2633624, 2467177, 2312355, 2168273,
        2034118, 1909144, 1792666, 1684053, 1582726, 1488151, 1399837, 1317332,
        1240216, 1168107, 1100648, 1037512, 978396, 923020, 871124, 822471,
        776837, 734018, 693823, 656077, 620616, 587288, 555953, 526480,
        498747, 472643, 448062, 424906, 403086, 382516, 363117, 344817,
        327547, 311243, 295847, 281301, 267556, 254562, 242274, 230650,
        219650, 209239, 199380, 190041, 181193, 172807, 164857, 157317,
        150164, 143376, 136933, 130816, 125005, 119485, 114239, 109252,
        104510, 100000, 95709, 91626, 87738, 84037, 80512, 77154,
        73953, 70903, 67995, 65221, 62576, 60051, 57642, 55342,
        53146, 51049, 49045, 47130, 45300, 43551, 41878, 40278,
        38748, 37283, 35882, 34540, 33255, 32025, 30846, 29717,
        28635, 27597, 26603, 25649, 24734, 23856, 23014, 22206,
        21431, 20686, 19970, 19283, 18623, 17989, 17380, 16794,
        16231, 15689, 15168, 14667, 14185, 13722, 13275, 12845,
        12431, 12033, 11649, 11279, 10923, 10580, 10249, 9930,
        9623, 9326, 9040, 8764, 8498, 8241, 7994, 7754,
        7523, 7300, 7085, 6877, 6676, 6482, 6295, 6113,
        5938, 5769, 5605, 5447, 5293, 5145, 5002, 4863,
        4729, 4599, 4474, 4352, 4234, 4120, 4009, 3902,
        3799, 3698, 3601, 3506, 3415, 3326
    };

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_write_en;
    logic [0:0]                  cfg_index;
    logic [ntct_pkg::CFG_W-1:0]  cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    ntct_pkg::in_item_t          in_data;
    logic                        out_valid;
    logic                        out_ready;
    ntct_pkg::out_item_t         out_data;

    ntct_pkg::in_item_t          samples_to_send [$];
    ntct_pkg::out_item_t         expected_readings [$];
    logic [ntct_pkg::CFG_W-1:0]  series_ohms;
    logic [ntct_pkg::THR_W-1:0]  absent_below;
    logic [ntct_pkg::TEMP_W-1:0] last_temp [ntct_pkg::CHANNELS_DEF];
    logic                        no_gaps = 1'b0;
    int                          mismatches = 0;
    int                          quiet_cycles = 0;

    ntc_thermistor_to_temperature i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic signed [ntct_pkg::TEMP_W-1:0] curve_temp(
        logic [ntct_pkg::RES_W-1:0] r);
        longint unsigned num;
        longint unsigned den;
        int              t;
        int              i;
        logic            hit;
        t   = HOTTEST_Q8;
        hit = 1'b0;
        if (r > THERM_CURVE[0])
            t = ntct_pkg::T_FIRST_Q8;
        else
        begin
            for (i = 0; i + 1 < ntct_pkg::TBL_FULL && !hit; i++)
            begin
                if (r <= THERM_CURVE[i] && r >= THERM_CURVE[i + 1])
                begin
                    num = THERM_CURVE[i] - r;
                    den = THERM_CURVE[i] - THERM_CURVE[i + 1];
                    t   = ntct_pkg::T_FIRST_Q8 + i * 256 +
                          int'((num * 512 + den) / (2 * den));
                    hit = 1'b1;
                end
            end
        end
        return t[ntct_pkg::TEMP_W-1:0];
    endfunction

    function automatic ntct_pkg::out_item_t convert_sample(ntct_pkg::in_item_t beat);
        ntct_pkg::out_item_t res;
        longint unsigned     ohms_x10;
        longint unsigned     span;
        res = '0;
        res.channel_out = beat.channel;
        if (beat.adc_code > absent_below)
        begin
            span     = (beat.adc_code < FULL_SCALE) ? FULL_SCALE - beat.adc_code : 0;
            ohms_x10 = (longint'(series_ohms) * 10 * span) / beat.adc_code;
            res.present           = 1'b1;
            res.resistance_tenths = (ohms_x10 > ntct_pkg::RES_MAX) ?
                                    ntct_pkg::RES_MAX : ohms_x10[ntct_pkg::RES_W-1:0];
            res.temperature       = curve_temp(res.resistance_tenths);
        end
        if (beat.channel < ntct_pkg::CHANNELS_DEF)
            last_temp[beat.channel] = res.temperature;
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_readings.push_back(convert_sample(in_data));
            if (!in_valid || in_ready)
            begin
                if (samples_to_send.size() != 0 && (no_gaps || $urandom_range(99) >= 18))
                begin
                    in_valid <= 1'b1;
                    in_data  <= samples_to_send.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        ntct_pkg::out_item_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $error("result beat with nothing expected: %p", out_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (out_data.channel_out !== want.channel_out)
                    begin
                        $error("channel_out: expected %0d, got %0d",
                               want.channel_out, out_data.channel_out);
                        mismatches++;
                    end
                    if (out_data.present !== want.present)
                    begin
                        $error("present: expected %0d, got %0d",
                               want.present, out_data.present);
                        mismatches++;
                    end
                    if (out_data.temperature !== want.temperature)
                    begin
                        $error("temperature: expected %0d, got %0d",
                               want.temperature, out_data.temperature);
                        mismatches++;
                    end
                    if (out_data.resistance_tenths !== want.resistance_tenths)
                    begin
                        $error("resistance_tenths: expected %0d, got %0d",
                               want.resistance_tenths, out_data.resistance_tenths);
                        mismatches++;
                    end
                end
            end
            out_ready <= no_gaps || $urandom_range(99) >= 18;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic settle();
        @(negedge clk);
        while (samples_to_send.size() != 0 || in_valid || expected_readings.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(ntct_pkg::cfg_idx_t idx, logic [ntct_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        if (idx == ntct_pkg::CFG_SERIES)
            series_ohms = value;
        else
            absent_below = value[ntct_pkg::THR_W-1:0];
    endtask

    // hold input until drained, then reprogram
    task automatic set_config(logic [ntct_pkg::CFG_W-1:0] ohms,
                              logic [ntct_pkg::THR_W-1:0] thr);
        settle();
        write_reg(ntct_pkg::CFG_SERIES, ohms);
        write_reg(ntct_pkg::CFG_THRESH, ntct_pkg::CFG_W'(thr));
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_beat(int ch, int code);
        ntct_pkg::in_item_t beat;
        beat.channel  = ntct_pkg::CH_W'(ch);
        beat.adc_code = ntct_pkg::CODE_W'(code);
        samples_to_send.push_back(beat);
    endtask

    initial
    begin
        longint unsigned            aim;
        int                         code;
        int                         count;
        logic [ntct_pkg::CFG_W-1:0] ohms;
        logic [ntct_pkg::THR_W-1:0] thr;

        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= ntct_pkg::CFG_SERIES;
        cfg_data     <= '0;
        series_ohms  = ntct_pkg::SERIES_RST;
        absent_below = ntct_pkg::THR_RST;
        foreach (last_temp[k])
            last_temp[k] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: absent, threshold edge, cold end, exact entry, hot end
        queue_beat(0, 0);
        queue_beat(1, int'(ntct_pkg::THR_RST));
        queue_beat(2, int'(ntct_pkg::THR_RST) + 1);
        queue_beat(3, 4095);
        queue_beat(0, 2048);
        queue_beat(1, 4094);
        queue_beat(2, 3964);
        queue_beat(3, 3965);
        queue_beat(2, 'hAAA);
        queue_beat(1, 'h555);
        queue_beat(3, 1000);

        // huge resistor: saturation and too cold
        set_config(20'd1000000, 12'd0);
        queue_beat(0, 0);
        queue_beat(1, 1);
        queue_beat(2, 4095);
        queue_beat(3, 2048);
        queue_beat(0, 3000);
        queue_beat(1, 3100);

        // zero resistor: hottest
        set_config(20'd0, 12'd4094);
        queue_beat(2, 4095);
        queue_beat(3, 4094);

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: begin ohms = ntct_pkg::SERIES_RST; thr = ntct_pkg::THR_RST; end
                1: begin ohms = 20'd1;        thr = 12'd0;    end
                2: begin ohms = 20'd1000000;  thr = ntct_pkg::THR_RST; end
                3: begin ohms = 20'd1000000;  thr = 12'd4095; end
                default:
                begin
                    ohms = ntct_pkg::CFG_W'($urandom_range(1, 1000000) >>
                                            $urandom_range(0, 19));
                    if (ohms == 0)
                        ohms = 20'd1;
                    thr = ntct_pkg::THR_W'($urandom_range(1) ? $urandom_range(0, 400) :
                                                               $urandom_range(0, 4095));
                end
            endcase
            set_config(ohms, thr);
            no_gaps = (p == 2);
            count   = (p == 3) ? 20 : 97;
            repeat (count)
            begin
                case ($urandom_range(9))
                    0: code = int'(absent_below) + int'($urandom_range(0, 4)) - 2;
                    1:
                    begin
                        case ($urandom_range(3))
                            0: code = 0;
                            1: code = 1;
                            2: code = FULL_SCALE - 2;
                            default: code = FULL_SCALE - 1;
                        endcase
                    end
                    2, 3:
                    begin
                        // aim at a resistance in and just beyond the table span
                        aim  = longint'(series_ohms) * 10;
                        code = int'((aim * FULL_SCALE) / (aim + $urandom_range(3000, 3500000)));
                    end
                    default: code = int'($urandom_range(0, FULL_SCALE - 1));
                endcase
                if (code < 0)
                    code = 0;
                if (code > FULL_SCALE - 1)
                    code = FULL_SCALE - 1;
                queue_beat(int'($urandom_range(0, ntct_pkg::CHANNELS_DEF - 1)), code);
            end
        end

        settle();
        no_gaps = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
